@@ sv/oale_pkg.sv @@
// Shared types and constants for the ordered array list engine.
package oale_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_AT    = 3'd1,
        ACT_APPEND    = 3'd2,
        ACT_ERASE     = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_FIND      = 3'd5,
        ACT_REPLACE   = 3'd6,
        ACT_DUMP      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CS_HOLD  = 2'd0,
        CS_LEFT  = 2'd1,
        CS_RIGHT = 2'd2,
        CS_LOAD  = 2'd3
    } t_cell_sel;

    typedef struct packed {
        t_cell_sel sel;
        logic      mload;
        logic      live;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

endpackage

@@ sv/oale_cell.sv @@
// One list cell: holds one entry and its match flag, trades data with its neighbors.
module oale_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oale_pkg::t_cell_ctl i_ctl,
    input  oale_pkg::t_word   i_key,
    input  oale_pkg::t_word   i_new,
    input  oale_pkg::t_word   i_left_data,
    input  oale_pkg::t_word   i_right_data,
    input  logic              i_right_match,
    output oale_pkg::t_word   o_data,
    output logic              o_match,
    output logic              o_hit
);
    import oale_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_match;
    logic  n_match;

    assign o_hit = i_ctl.live && (r_data == i_key);

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        unique case (i_ctl.sel)
            CS_HOLD:  n_data = r_data;
            CS_LEFT:  n_data = i_left_data;
            CS_RIGHT: begin
                n_data  = i_right_data;
                n_match = i_right_match;
            end
            CS_LOAD:  n_data = i_new;
            default:  n_data = r_data;
        endcase
        if (i_ctl.mload) begin
            n_match = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

@@ sv/ordered_array_list_engine.sv @@
// Top level: command decode, scan sequencer and output register over a row of list cells.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  command | in        | i_in_valid / o_in_stall   | i_action, i_value, i_position
//  result  | out       | o_out_valid / i_out_stall | o_status, o_found, o_result_position,
//          |           |                           | o_result_value, o_list_length,
//          |           |                           | o_is_full, o_is_empty, o_last
//
// Insert, erase, replace and clear finish in the accept cycle: every cell takes its
// neighbor or the new word at once. Find with a hit and dump rotate the row one full turn
// through cell 0, at most one word out per cycle, and a stalled result word holds the
// rotation; the block stalls commands until the turn ends. Reset (synchronous,
// active low) empties the list; the entries themselves are not cleared.
module ordered_array_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic signed [31:0] i_value,
    input  logic [4:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [3:0]  o_result_position,
    output logic signed [31:0] o_result_value,
    output logic [4:0]  o_list_length,
    output logic        o_is_full,
    output logic        o_is_empty,
    output logic        o_last
);
    import oale_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_step, n_step;
    logic                   r_dump, n_dump;

    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic                   r_found, n_found;
    logic [3:0]             r_rpos, n_rpos;
    t_word                  r_rval, n_rval;
    logic [CNT_W-1:0]       r_len, n_len;
    logic                   r_last, n_last;

    t_word                  w_data [CAPACITY];
    logic [CAPACITY-1:0]    w_match;
    logic [CAPACITY-1:0]    w_hit;
    t_cell_ctl              w_ctl [CAPACITY];

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_go_scan;
    logic                   w_scan_done;
    t_action                w_act;

    assign w_act      = t_action'(i_action);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_go_scan  = w_accept && (r_count != '0)
                        && ((w_act == ACT_DUMP) || ((w_act == ACT_FIND) && (|w_hit)));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_word w_left;
            t_word w_right;
            logic  w_right_match;
            if (g == 0) begin : g_head
                assign w_left = i_value;
            end else begin : g_body
                assign w_left = w_data[g-1];
            end
            // wrap the tail back to the head so a full rotation restores order
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right       = w_data[0];
                assign w_right_match = 1'b0;
            end else begin : g_mid
                assign w_right       = w_data[g+1];
                assign w_right_match = w_match[g+1];
            end
            oale_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl[g]),
                .i_key         (i_value),
                .i_new         (i_value),
                .i_left_data   (w_left),
                .i_right_data  (w_right),
                .i_right_match (w_right_match),
                .o_data        (w_data[g]),
                .o_match       (w_match[g]),
                .o_hit         (w_hit[g])
            );
        end
    endgenerate

    // scan ends when the last rotation step advances
    logic w_emit;
    logic w_advance;
    assign w_emit      = (32'(r_step) < 32'(r_count)) && (r_dump || w_match[0]);
    assign w_advance   = !w_emit || w_out_free;
    assign w_scan_done = w_advance && (32'(r_step) == 32'(CAPACITY - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_go_scan) begin
                n_state = ST_SCAN;
            end
            ST_SCAN: if (w_scan_done) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cell control, count and result word
    always_comb begin
        logic [31:0] cnt32;
        logic [31:0] pos32;
        logic [31:0] ins32;
        logic        ins_ok;

        cnt32  = 32'(r_count);
        pos32  = 32'(i_position);
        ins32  = '0;
        ins_ok = 1'b0;

        n_count     = r_count;
        n_step      = r_step;
        n_dump      = r_dump;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_found     = r_found;
        n_rpos      = r_rpos;
        n_rval      = r_rval;
        n_len       = r_len;
        n_last      = r_last;

        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i].sel   = CS_HOLD;
            w_ctl[i].mload = 1'b0;
            w_ctl[i].live  = (32'(i) < cnt32);
        end

        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                n_status = STS_OK;
                n_found  = 1'b0;
                n_rpos   = '0;
                n_rval   = '0;
                n_last   = 1'b1;
                unique case (w_act)
                    ACT_INS_FRONT, ACT_INS_AT, ACT_APPEND: begin
                        if (cnt32 >= 32'(CAPACITY)) begin
                            n_status = STS_FULL;
                        end else begin
                            ins_ok = 1'b1;
                            if (w_act == ACT_INS_FRONT) begin
                                ins32 = '0;
                            end else if (w_act == ACT_APPEND || pos32 > cnt32) begin
                                ins32 = cnt32;
                            end else begin
                                ins32 = pos32;
                            end
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    ACT_ERASE, ACT_REPLACE: begin
                        if (r_count == '0) begin
                            n_status = STS_EMPTY;
                        end else if (pos32 >= cnt32) begin
                            n_status = STS_RANGE;
                        end else if (w_act == ACT_ERASE) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    ACT_CLEAR: n_count = '0;
                    ACT_FIND, ACT_DUMP: begin
                        if (r_count == '0) begin
                            n_status = STS_EMPTY;
                        end
                    end
                    default: n_status = STS_OK;
                endcase

                for (int i = 0; i < CAPACITY; i++) begin
                    if (ins_ok) begin
                        if (32'(i) > ins32) begin
                            w_ctl[i].sel = CS_LEFT;
                        end else if (32'(i) == ins32) begin
                            w_ctl[i].sel = CS_LOAD;
                        end
                    end else if (r_count != '0 && pos32 < cnt32) begin
                        if (w_act == ACT_ERASE && 32'(i) >= pos32) begin
                            w_ctl[i].sel = CS_RIGHT;
                        end else if (w_act == ACT_REPLACE && 32'(i) == pos32) begin
                            w_ctl[i].sel = CS_LOAD;
                        end
                    end
                    w_ctl[i].mload = w_go_scan;
                end

                if (w_go_scan) begin
                    n_step = '0;
                    n_dump = (w_act == ACT_DUMP);
                end else begin
                    n_out_valid = 1'b1;
                    n_len       = n_count;
                end
            end
            ST_SCAN: if (w_advance) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    w_ctl[i].sel = CS_RIGHT;
                end
                n_step = r_step + IDX_W'(1);
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_status    = STS_OK;
                    n_found     = 1'b1;
                    n_rpos      = 4'(r_step);
                    n_rval      = w_data[0];
                    n_len       = r_count;
                    if (r_dump) begin
                        n_last = (32'(r_step) + 32'd1 == cnt32);
                    end else begin
                        n_last = ~|w_match[CAPACITY-1:1];
                    end
                end
            end
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_dump   <= n_dump;
        r_status <= n_status;
        r_found  <= n_found;
        r_rpos   <= n_rpos;
        r_rval   <= n_rval;
        r_len    <= n_len;
        r_last   <= n_last;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_found           = r_found;
    assign o_result_position = r_rpos;
    assign o_result_value    = r_rval;
    assign o_list_length     = 5'(r_len);
    assign o_is_full         = (32'(r_len) == 32'(CAPACITY));
    assign o_is_empty        = (r_len == '0);
    assign o_last            = r_last;

endmodule

@@ tb/ordered_array_list_engine_test.sv @@
// Self-checking testbench for the ordered array list engine: table-driven and random commands.
`timescale 1ns / 1ps

module ordered_array_list_engine_test;
    import oale_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        t_status      status;
        logic         found;
        logic [3:0]   rpos;
        t_word        rval;
        logic [4:0]   len;
        logic         full;
        logic         empty;
        logic         last;
    } t_list_result;

    typedef struct packed {
        t_action      act;
        t_word        val;
        logic [4:0]   pos;
        logic         typed;
        t_status      sts;
        logic [4:0]   len;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_action;
    logic signed [31:0] i_value;
    logic [4:0]         i_position;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic               o_found;
    logic [3:0]         o_result_position;
    logic signed [31:0] o_result_value;
    logic [4:0]         o_list_length;
    logic               o_is_full;
    logic               o_is_empty;
    logic               o_last;

    // shadow copy of the list
    t_word        shadow_words [CAPACITY];
    int           shadow_len;
    t_list_result awaited_results [$];
    t_word        word_pool [4];

    int  mismatch_count;
    int  commands_sent;
    int  results_checked;
    int  full_rejects;
    int  find_hits;
    int  hold_cycles;
    bit  hold_request;
    bit  quiet_spell;

    ordered_array_list_engine u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_value           (i_value),
        .i_position        (i_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_found           (o_found),
        .o_result_position (o_result_position),
        .o_result_value    (o_result_value),
        .o_list_length     (o_list_length),
        .o_is_full         (o_is_full),
        .o_is_empty        (o_is_empty),
        .o_last            (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_list_result status_only(input t_status sts, input int len);
        t_list_result r;
        r.status = sts;
        r.found  = 1'b0;
        r.rpos   = '0;
        r.rval   = '0;
        r.len    = len[4:0];
        r.full   = (len == CAPACITY);
        r.empty  = (len == 0);
        r.last   = 1'b1;
        return r;
    endfunction

    // Work out the words a command produces and advance the shadow list.
    task automatic predict_command(input t_action act, input t_word val, input logic [4:0] pos);
        int slot;
        int hits;
        t_list_result r;
        hits = 0;
        case (act)
            ACT_INS_FRONT, ACT_INS_AT, ACT_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    full_rejects++;
                    awaited_results.push_back(status_only(STS_FULL, shadow_len));
                end else begin
                    if (act == ACT_INS_FRONT)
                        slot = 0;
                    else if (act == ACT_APPEND || int'(pos) > shadow_len)
                        slot = shadow_len;
                    else
                        slot = int'(pos);
                    for (int i = shadow_len; i > slot; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[slot] = val;
                    shadow_len++;
                    awaited_results.push_back(status_only(STS_OK, shadow_len));
                end
            end
            ACT_ERASE, ACT_REPLACE: begin
                if (shadow_len == 0) begin
                    awaited_results.push_back(status_only(STS_EMPTY, shadow_len));
                end else if (int'(pos) >= shadow_len) begin
                    awaited_results.push_back(status_only(STS_RANGE, shadow_len));
                end else begin
                    if (act == ACT_ERASE) begin
                        for (int i = int'(pos); i + 1 < shadow_len; i++)
                            shadow_words[i] = shadow_words[i+1];
                        shadow_len--;
                    end else begin
                        shadow_words[pos[3:0]] = val;
                    end
                    awaited_results.push_back(status_only(STS_OK, shadow_len));
                end
            end
            ACT_CLEAR: begin
                shadow_len = 0;
                awaited_results.push_back(status_only(STS_OK, shadow_len));
            end
            default: begin
                if (shadow_len == 0) begin
                    awaited_results.push_back(status_only(STS_EMPTY, shadow_len));
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        if (act == ACT_DUMP || shadow_words[i] == val) begin
                            r       = status_only(STS_OK, shadow_len);
                            r.found = 1'b1;
                            r.rpos  = i[3:0];
                            r.rval  = shadow_words[i];
                            r.last  = 1'b0;
                            awaited_results.push_back(r);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        awaited_results.push_back(status_only(STS_OK, shadow_len));
                    else
                        awaited_results[awaited_results.size()-1].last = 1'b1;
                    if (act == ACT_FIND)
                        find_hits += hits;
                end
            end
        endcase
    endtask

    // Offer one command word; entered and left just after a falling edge.
    task automatic send_command(input t_action act, input t_word val, input logic [4:0] pos,
                                input logic typed, input t_status want_sts, input int want_len);
        int before_n;
        while (!quiet_spell && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        before_n = awaited_results.size();
        predict_command(act, val, pos);
        if (typed) begin
            // hand-written expectation replaces the predicted one
            while (awaited_results.size() > before_n)
                void'(awaited_results.pop_back());
            awaited_results.push_back(status_only(want_sts, want_len));
        end
        commands_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_action pick_action(input bit fill_mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (fill_mode) begin
            if (roll < 75)
                return t_action'($urandom_range(0, 2));
            return (roll < 85) ? ACT_FIND : (roll < 93) ? ACT_REPLACE : ACT_DUMP;
        end
        if (roll < 30) return t_action'($urandom_range(0, 2));
        if (roll < 55) return ACT_ERASE;
        if (roll < 58) return ACT_CLEAR;
        if (roll < 75) return ACT_FIND;
        if (roll < 88) return ACT_REPLACE;
        return ACT_DUMP;
    endfunction

    function automatic logic [4:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return 5'($urandom_range(0, shadow_len));
        if (roll < 92)
            return 5'($urandom_range(0, CAPACITY));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                log_mismatch("result word with nothing expected");
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    log_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_found !== want.found)
                    log_mismatch($sformatf("found %0b, want %0b", o_found, want.found));
                if (o_result_position !== want.rpos)
                    log_mismatch($sformatf("position %0d, want %0d",
                                           o_result_position, want.rpos));
                if (o_result_value !== want.rval)
                    log_mismatch($sformatf("value %0d, want %0d", o_result_value, want.rval));
                if (o_list_length !== want.len)
                    log_mismatch($sformatf("length %0d, want %0d", o_list_length, want.len));
                if (o_is_full !== want.full)
                    log_mismatch($sformatf("full %0b, want %0b", o_is_full, want.full));
                if (o_is_empty !== want.empty)
                    log_mismatch($sformatf("empty %0b, want %0b", o_is_empty, want.empty));
                if (o_last !== want.last)
                    log_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        bit hold_taken;
        hold_taken  = 1'b0;
        i_out_stall = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken && hold_cycles == 0) begin
                hold_taken  = 1'b1;
                hold_cycles = HOLD_CYCLES;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_spell && $urandom_range(0, 99) < 8;
            end
        end
    end

    initial begin
        t_plan_row  plan [22];
        t_action    act;
        t_word      val;
        logic [4:0] pos;
        bit         fill_mode;

        plan = '{
            '{ACT_FIND,      32'sd5,            5'd0,  1'b1, STS_EMPTY, 5'd0},
            '{ACT_DUMP,      32'sd0,            5'd0,  1'b1, STS_EMPTY, 5'd0},
            '{ACT_ERASE,     32'sd0,            5'd0,  1'b1, STS_EMPTY, 5'd0},
            '{ACT_REPLACE,   32'sd0,            5'd0,  1'b1, STS_EMPTY, 5'd0},
            '{ACT_INS_FRONT, 32'sh7FFF_FFFF,    5'd0,  1'b1, STS_OK,    5'd1},
            '{ACT_APPEND,    32'sh8000_0000,    5'd31, 1'b1, STS_OK,    5'd2},
            '{ACT_INS_AT,    -32'sd1,           5'd31, 1'b1, STS_OK,    5'd3},
            '{ACT_INS_AT,    32'sd0,            5'd3,  1'b1, STS_OK,    5'd4},
            '{ACT_INS_FRONT, 32'sd1,            5'd0,  1'b1, STS_OK,    5'd5},
            '{ACT_ERASE,     32'sd0,            5'd5,  1'b1, STS_RANGE, 5'd5},
            '{ACT_REPLACE,   32'sd0,            5'd31, 1'b1, STS_RANGE, 5'd5},
            '{ACT_FIND,      -32'sd1,           5'd0,  1'b0, STS_OK,    5'd0},
            '{ACT_FIND,      32'sd12345,        5'd0,  1'b0, STS_OK,    5'd0},
            '{ACT_REPLACE,   32'sh8000_0000,    5'd4,  1'b1, STS_OK,    5'd5},
            '{ACT_FIND,      32'sh8000_0000,    5'd0,  1'b0, STS_OK,    5'd0},
            '{ACT_DUMP,      32'sd0,            5'd0,  1'b0, STS_OK,    5'd0},
            '{ACT_ERASE,     32'sd0,            5'd0,  1'b1, STS_OK,    5'd4},
            '{ACT_ERASE,     32'sd0,            5'd3,  1'b1, STS_OK,    5'd3},
            '{ACT_CLEAR,     32'sd0,            5'd0,  1'b1, STS_OK,    5'd0},
            '{ACT_CLEAR,     32'sd0,            5'd0,  1'b1, STS_OK,    5'd0},
            '{ACT_APPEND,    32'sd42,           5'd0,  1'b1, STS_OK,    5'd1},
            '{ACT_DUMP,      32'sd0,            5'd0,  1'b0, STS_OK,    5'd0}
        };

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_action        = '0;
        i_value         = '0;
        i_position      = '0;
        shadow_len      = 0;
        mismatch_count  = 0;
        commands_sent   = 0;
        results_checked = 0;
        full_rejects    = 0;
        find_hits       = 0;
        hold_request    = 1'b0;
        quiet_spell     = 1'b0;
        foreach (shadow_words[i])
            shadow_words[i] = '0;
        word_pool[0] = 32'sh7FFF_FFFF;
        word_pool[1] = 32'sh8000_0000;
        word_pool[2] = 32'sd0;
        word_pool[3] = t_word'($urandom);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i])
            send_command(plan[i].act, plan[i].val, plan[i].pos,
                         plan[i].typed, plan[i].sts, int'(plan[i].len));

        // alternate fill-heavy and churn episodes; a few values repeat so finds hit
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            fill_mode   = ((k / 40) % 2) == 0;
            quiet_spell = (k >= 200 && k < 280);
            if (k == 100)
                hold_request = 1'b1;
            act = pick_action(fill_mode);
            if ($urandom_range(0, 99) < 60)
                val = word_pool[$urandom_range(0, 3)];
            else
                val = t_word'($urandom);
            pos = pick_position();
            send_command(act, val, pos, 1'b0, STS_OK, 0);
        end
        i_in_valid  <= 1'b0;
        quiet_spell  = 1'b0;

        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * CAPACITY) @(posedge i_clk);

        $display("Covered %0d commands and %0d result words, with %0d full rejects",
                 commands_sent, results_checked, full_rejects);
        $display("and %0d find hits, plus one long result-side hold-off.", find_hits);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/oale_pkg.sv
sv/oale_cell.sv
sv/ordered_array_list_engine.sv
tb/ordered_array_list_engine_test.sv
